// ===== design/scan_window_obstacle_guard_macros.svh =====
// Assertion macros shared by the checker of the scan window obstacle guard.
// Depends on nothing; included by files that assert.
`ifndef SCAN_WINDOW_OBSTACLE_GUARD_MACROS_SVH
`define SCAN_WINDOW_OBSTACLE_GUARD_MACROS_SVH

// Same-cycle implication, masked during reset
`define SWOG_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swog assertion failed");

// Next-cycle implication, masked during reset
`define SWOG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swog assertion failed");

`endif

// ===== design/swog_pkg.sv =====
// Package for the scan window obstacle guard: register indexes, event codes
// and the queue status type. Depends on nothing.
package swog_pkg;

  // Configuration register indexes
  localparam int REG_INDEX_BITS = 3;
  localparam logic [REG_INDEX_BITS-1:0] REG_HIT_THRESHOLD      = 3'd0;
  localparam logic [REG_INDEX_BITS-1:0] REG_CLEAR_THRESHOLD    = 3'd1;
  localparam logic [REG_INDEX_BITS-1:0] REG_HITS_NEEDED        = 3'd2;
  localparam logic [REG_INDEX_BITS-1:0] REG_CLEARS_NEEDED      = 3'd3;
  localparam logic [REG_INDEX_BITS-1:0] REG_WINDOW_FIRST_INDEX = 3'd4;
  localparam logic [REG_INDEX_BITS-1:0] REG_WINDOW_LAST_INDEX  = 3'd5;
  localparam logic [REG_INDEX_BITS-1:0] REG_MIN_VALID_RANGE    = 3'd6;
  localparam logic [REG_INDEX_BITS-1:0] REG_MAX_VALID_RANGE    = 3'd7;

  // Event codes of a result
  localparam int EVENT_BITS = 2;
  localparam logic [EVENT_BITS-1:0] EVT_NONE     = 2'd0;
  localparam logic [EVENT_BITS-1:0] EVT_DETECTED = 2'd1;
  localparam logic [EVENT_BITS-1:0] EVT_CLEARED  = 2'd2;

  // Fill status of the scan summary queue
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== design/swog_front.sv =====
// Front part: qualifies samples against window and bounds and keeps the
// running minimum of a scan. Depends on nothing outside this file.
module swog_front #(
  parameter int RANGE_BITS = 16,
  parameter int INDEX_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [RANGE_BITS-1:0] sample_range,
  input  logic                  sample_finite,
  input  logic                  scan_end,
  input  logic [INDEX_BITS-1:0] window_first_index,
  input  logic [INDEX_BITS-1:0] window_last_index,
  input  logic [RANGE_BITS-1:0] min_valid_range,
  input  logic [RANGE_BITS-1:0] max_valid_range,
  output logic                  push,
  output logic [RANGE_BITS:0]   push_data
);

  logic [INDEX_BITS-1:0] sample_position;
  logic [RANGE_BITS-1:0] running_minimum;
  logic                  any_valid_seen;
  logic                  in_window;
  logic [RANGE_BITS-1:0] minimum_next;
  logic                  any_next;

  // Sample qualification and minimum update
  always_comb begin
    in_window = (sample_position >= window_first_index) &&
                (sample_position <= window_last_index) && sample_finite &&
                (sample_range >= min_valid_range) && (sample_range <= max_valid_range);
    minimum_next = running_minimum;
    if (in_window && (!any_valid_seen || (sample_range < running_minimum))) begin
      minimum_next = sample_range;
    end
    any_next = any_valid_seen | in_window;
  end

  // Scan summary goes to the queue on the last sample
  assign push      = accept & scan_end;
  assign push_data = {any_next, any_next ? minimum_next : {RANGE_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_position <= '0;
      running_minimum <= '1;
      any_valid_seen  <= 1'b0;
    end else if (accept) begin
      if (scan_end) begin
        sample_position <= '0;
        running_minimum <= '1;
        any_valid_seen  <= 1'b0;
      end else begin
        running_minimum <= minimum_next;
        any_valid_seen  <= any_next;
        if (sample_position != {INDEX_BITS{1'b1}}) begin
          sample_position <= sample_position + INDEX_BITS'(1);
        end
      end
    end
  end

endmodule

// ===== design/swog_queue.sv =====
// Two-entry queue of scan summaries between front and back parts.
// Depends on swog_pkg for the status type.
module swog_queue import swog_pkg::*; #(
  parameter int DATA_BITS = 17
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [DATA_BITS-1:0] push_data,
  input  logic                 pop,
  output logic [DATA_BITS-1:0] head_data,
  output queue_status_t        status
);

  logic [DATA_BITS-1:0] entries [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           count;

  assign head_data    = entries[rd_ptr];
  assign status.full  = count[1];
  assign status.empty = (count == 2'd0);

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/swog_back.sv =====
// Back part: hysteresis detector with saturating streaks and the output
// register. Depends on swog_pkg for event codes and queue status.
module swog_back import swog_pkg::*; #(
  parameter int RANGE_BITS  = 16,
  parameter int STREAK_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [RANGE_BITS:0]    head_data,
  input  queue_status_t          q_status,
  output logic                   pop,
  input  logic [RANGE_BITS-1:0]  hit_threshold,
  input  logic [RANGE_BITS-1:0]  clear_threshold,
  input  logic [STREAK_BITS-1:0] hits_needed,
  input  logic [STREAK_BITS-1:0] clears_needed,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [RANGE_BITS-1:0]  front_minimum,
  output logic                   minimum_found,
  output logic                   obstacle_present,
  output logic [EVENT_BITS-1:0]  event_code
);

  localparam logic [STREAK_BITS-1:0] StreakMax = {STREAK_BITS{1'b1}};

  logic                   obstacle_flag;
  logic [STREAK_BITS-1:0] hit_streak;
  logic [STREAK_BITS-1:0] clear_streak;
  logic                   flag_next;
  logic [STREAK_BITS-1:0] hit_streak_next;
  logic [STREAK_BITS-1:0] clear_streak_next;
  logic [STREAK_BITS-1:0] hit_bump;
  logic [STREAK_BITS-1:0] clear_bump;
  logic [EVENT_BITS-1:0]  event_next;
  logic                   found;
  logic [RANGE_BITS-1:0]  minimum;

  assign found   = head_data[RANGE_BITS];
  assign minimum = head_data[RANGE_BITS-1:0];
  assign pop     = !q_status.empty && (!out_valid || out_ready);

  // Detector update for the summary at the queue head
  always_comb begin
    hit_bump   = (hit_streak == StreakMax) ? StreakMax : hit_streak + STREAK_BITS'(1);
    clear_bump = (clear_streak == StreakMax) ? StreakMax : clear_streak + STREAK_BITS'(1);
    flag_next         = obstacle_flag;
    hit_streak_next   = hit_streak;
    clear_streak_next = clear_streak;
    event_next        = EVT_NONE;
    if (found) begin
      if (!obstacle_flag) begin
        if (minimum <= hit_threshold) begin
          hit_streak_next = hit_bump;
          if (hit_bump >= hits_needed) begin
            flag_next         = 1'b1;
            clear_streak_next = '0;
            event_next        = EVT_DETECTED;
          end
        end else begin
          hit_streak_next = '0;
        end
      end else begin
        if (minimum >= clear_threshold) begin
          clear_streak_next = clear_bump;
          if (clear_bump >= clears_needed) begin
            flag_next       = 1'b0;
            hit_streak_next = '0;
            event_next      = EVT_CLEARED;
          end
        end else begin
          clear_streak_next = '0;
        end
      end
    end
  end

  // Detector state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      obstacle_flag <= 1'b0;
      hit_streak    <= '0;
      clear_streak  <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (pop) begin
        obstacle_flag <= flag_next;
        hit_streak    <= hit_streak_next;
        clear_streak  <= clear_streak_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      front_minimum    <= minimum;
      minimum_found    <= found;
      obstacle_present <= flag_next;
      event_code       <= event_next;
    end
  end

endmodule

// ===== design/scan_window_obstacle_guard.sv =====
// Scan window obstacle guard: windowed minimum of a range scan with a
// debounced obstacle detector.
//
// Input channel (in_valid/in_ready) takes one range sample per transaction,
// with sample_finite and scan_end flags; samples are indexed by arrival
// order within a scan (index saturates at its maximum).
// Output channel (out_valid/out_ready) gives one result per scan: the
// windowed minimum, whether one was found, the obstacle flag and an event.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data);
// the user must see that it is written only while the block is idle, as
// the block itself does not enforce this. Throughput: one sample per cycle
// while in_ready is high, set by the combinational compare and minimum
// update in the front part. The summary of a scan enters the queue when its
// last sample is accepted and moves on to the output register once free.
// Reset clears the scan state, detector state, queue and output valid, and
// loads the register defaults. When the receiver stalls, results wait in the
// output register and the two-entry summary queue; in_ready drops only once
// that queue is full.
module scan_window_obstacle_guard import swog_pkg::*; #(
  parameter int RANGE_BITS  = 16,
  parameter int INDEX_BITS  = 12,
  parameter int STREAK_BITS = 8,
  localparam int WideBits   = (RANGE_BITS > INDEX_BITS) ? RANGE_BITS : INDEX_BITS,
  localparam int CfgBits    = (WideBits > STREAK_BITS) ? WideBits : STREAK_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [REG_INDEX_BITS-1:0] cfg_index,
  input  logic [CfgBits-1:0]        cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [RANGE_BITS-1:0]     sample_range,
  input  logic                      sample_finite,
  input  logic                      scan_end,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [RANGE_BITS-1:0]     front_minimum,
  output logic                      minimum_found,
  output logic                      obstacle_present,
  output logic [EVENT_BITS-1:0]     event_code
);

  logic [RANGE_BITS-1:0]  hit_threshold;
  logic [RANGE_BITS-1:0]  clear_threshold;
  logic [STREAK_BITS-1:0] hits_needed;
  logic [STREAK_BITS-1:0] clears_needed;
  logic [INDEX_BITS-1:0]  window_first_index;
  logic [INDEX_BITS-1:0]  window_last_index;
  logic [RANGE_BITS-1:0]  min_valid_range;
  logic [RANGE_BITS-1:0]  max_valid_range;

  logic                   accept;
  logic                   push;
  logic                   pop;
  logic [RANGE_BITS:0]    push_data;
  logic [RANGE_BITS:0]    head_data;
  queue_status_t          q_status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_threshold      <= RANGE_BITS'(200);
      clear_threshold    <= RANGE_BITS'(300);
      hits_needed        <= STREAK_BITS'(1);
      clears_needed      <= STREAK_BITS'(1);
      window_first_index <= '0;
      window_last_index  <= '1;
      min_valid_range    <= '0;
      max_valid_range    <= '1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HIT_THRESHOLD:      hit_threshold      <= cfg_data[RANGE_BITS-1:0];
        REG_CLEAR_THRESHOLD:    clear_threshold    <= cfg_data[RANGE_BITS-1:0];
        REG_HITS_NEEDED:        hits_needed        <= cfg_data[STREAK_BITS-1:0];
        REG_CLEARS_NEEDED:      clears_needed      <= cfg_data[STREAK_BITS-1:0];
        REG_WINDOW_FIRST_INDEX: window_first_index <= cfg_data[INDEX_BITS-1:0];
        REG_WINDOW_LAST_INDEX:  window_last_index  <= cfg_data[INDEX_BITS-1:0];
        REG_MIN_VALID_RANGE:    min_valid_range    <= cfg_data[RANGE_BITS-1:0];
        REG_MAX_VALID_RANGE:    max_valid_range    <= cfg_data[RANGE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Input handshake
  assign in_ready = !q_status.full;
  assign accept   = in_valid & in_ready;

  swog_front #(
    .RANGE_BITS(RANGE_BITS),
    .INDEX_BITS(INDEX_BITS)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .sample_range      (sample_range),
    .sample_finite     (sample_finite),
    .scan_end          (scan_end),
    .window_first_index(window_first_index),
    .window_last_index (window_last_index),
    .min_valid_range   (min_valid_range),
    .max_valid_range   (max_valid_range),
    .push              (push),
    .push_data         (push_data)
  );

  swog_queue #(
    .DATA_BITS(RANGE_BITS + 1)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .head_data(head_data),
    .status   (q_status)
  );

  swog_back #(
    .RANGE_BITS (RANGE_BITS),
    .STREAK_BITS(STREAK_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .head_data       (head_data),
    .q_status        (q_status),
    .pop             (pop),
    .hit_threshold   (hit_threshold),
    .clear_threshold (clear_threshold),
    .hits_needed     (hits_needed),
    .clears_needed   (clears_needed),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .front_minimum   (front_minimum),
    .minimum_found   (minimum_found),
    .obstacle_present(obstacle_present),
    .event_code      (event_code)
  );

endmodule

// ===== design/scan_window_obstacle_guard_checker.sv =====
// Port-level assertions for the scan window obstacle guard, bound to the top.
// Depends on swog_pkg and scan_window_obstacle_guard_macros.svh.
`include "scan_window_obstacle_guard_macros.svh"

module scan_window_obstacle_guard_sva import swog_pkg::*; #(
  parameter int RANGE_BITS = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [RANGE_BITS-1:0] front_minimum,
  input logic                  minimum_found,
  input logic                  obstacle_present,
  input logic [EVENT_BITS-1:0] event_code
);

  logic [RANGE_BITS+EVENT_BITS+1:0] payload;
  logic                             empty_ok;
  logic                             flag_ok;
  logic                             code_ok;

  assign payload  = {front_minimum, minimum_found, obstacle_present, event_code};
  assign empty_ok = (front_minimum == '0) && (event_code == EVT_NONE);
  assign flag_ok  = (event_code != EVT_DETECTED || obstacle_present) &&
                    (event_code != EVT_CLEARED || !obstacle_present);
  assign code_ok  = (event_code == EVT_NONE) || (event_code == EVT_DETECTED) ||
                    (event_code == EVT_CLEARED);

  // A stalled result holds
  `SWOG_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(payload))

  // An empty scan reports zero and no event
  `SWOG_ASSERT_NOW(a_empty_scan, clk, rst, out_valid && !minimum_found, empty_ok)

  // Events agree with the flag they leave behind
  `SWOG_ASSERT_NOW(a_event_flag, clk, rst, out_valid, flag_ok)

  // Only defined event codes appear
  `SWOG_ASSERT_NOW(a_event_code, clk, rst, out_valid, code_ok)

endmodule

bind scan_window_obstacle_guard scan_window_obstacle_guard_sva #(
  .RANGE_BITS(RANGE_BITS)
) u_checker (.*);

// ===== dv/scan_window_obstacle_guard_checker.sv =====
`timescale 1ns / 100ps
// Checker for the scan window obstacle guard: mirrors the register writes,
// predicts the summary of every scan and compares each output transaction.
// Depends on swog_pkg.
module scan_window_obstacle_guard_checker import swog_pkg::*; #(
  parameter int RANGE_BITS  = 16,
  parameter int INDEX_BITS  = 12,
  parameter int STREAK_BITS = 8,
  parameter int CFG_BITS    = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [REG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [RANGE_BITS-1:0]     sample_range,
  input  logic                      sample_finite,
  input  logic                      scan_end,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [RANGE_BITS-1:0]     front_minimum,
  input  logic                      minimum_found,
  input  logic                      obstacle_present,
  input  logic [EVENT_BITS-1:0]     event_code,
  output int                        mismatches,
  output int                        outstanding
);

  typedef struct packed {
    logic [RANGE_BITS-1:0] minimum;
    logic                  found;
    logic                  present;
    logic [EVENT_BITS-1:0] evt;
  } scan_summary_t;

  // Register mirror
  logic [RANGE_BITS-1:0]  trig_mm, rel_mm, valid_lo, valid_hi;
  logic [STREAK_BITS-1:0] hits_req, clears_req;
  logic [INDEX_BITS-1:0]  win_lo, win_hi;

  // Scan and detector state
  logic [INDEX_BITS-1:0]  scan_pos;
  logic [RANGE_BITS-1:0]  scan_min;
  logic                   scan_has_valid;
  logic                   obstacle_on;
  logic [STREAK_BITS-1:0] hit_run, clear_run;

  scan_summary_t summaries_due[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic void restart_scan();
    scan_pos       = '0;
    scan_min       = '1;
    scan_has_valid = 1'b0;
  endfunction

  function automatic void restore_defaults();
    trig_mm     = 200;
    rel_mm      = 300;
    hits_req    = 1;
    clears_req  = 1;
    win_lo      = '0;
    win_hi      = '1;
    valid_lo    = '0;
    valid_hi    = '1;
    obstacle_on = 1'b0;
    hit_run     = '0;
    clear_run   = '0;
    restart_scan();
  endfunction

  function automatic void apply_reg(input logic [REG_INDEX_BITS-1:0] idx,
                                    input logic [CFG_BITS-1:0] val);
    case (idx)
      REG_HIT_THRESHOLD:      trig_mm    = val[RANGE_BITS-1:0];
      REG_CLEAR_THRESHOLD:    rel_mm     = val[RANGE_BITS-1:0];
      REG_HITS_NEEDED:        hits_req   = val[STREAK_BITS-1:0];
      REG_CLEARS_NEEDED:      clears_req = val[STREAK_BITS-1:0];
      REG_WINDOW_FIRST_INDEX: win_lo     = val[INDEX_BITS-1:0];
      REG_WINDOW_LAST_INDEX:  win_hi     = val[INDEX_BITS-1:0];
      REG_MIN_VALID_RANGE:    valid_lo   = val[RANGE_BITS-1:0];
      REG_MAX_VALID_RANGE:    valid_hi   = val[RANGE_BITS-1:0];
      default: ;
    endcase
  endfunction

  // Saturating streak increment
  function automatic logic [STREAK_BITS-1:0] streak_up(input logic [STREAK_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Fold one sample into the scan; at the end of a scan, run the debounce
  // and queue the summary it should produce
  function automatic void absorb_sample(input logic [RANGE_BITS-1:0] rng,
                                        input logic fin, input logic last);
    scan_summary_t s;
    if (scan_pos >= win_lo && scan_pos <= win_hi && fin &&
        rng >= valid_lo && rng <= valid_hi) begin
      if (!scan_has_valid || rng < scan_min) scan_min = rng;
      scan_has_valid = 1'b1;
    end
    if (!last) begin
      if (scan_pos != '1) scan_pos = scan_pos + 1'b1;
      return;
    end
    s     = '0;
    s.evt = EVT_NONE;
    // an empty scan leaves the detector alone
    if (scan_has_valid) begin
      s.minimum = scan_min;
      s.found   = 1'b1;
      if (!obstacle_on) begin
        if (scan_min <= trig_mm) begin
          hit_run = streak_up(hit_run);
          if (hit_run >= hits_req) begin
            obstacle_on = 1'b1;
            clear_run   = '0;
            s.evt       = EVT_DETECTED;
          end
        end else begin
          hit_run = '0;
        end
      end else begin
        if (scan_min >= rel_mm) begin
          clear_run = streak_up(clear_run);
          if (clear_run >= clears_req) begin
            obstacle_on = 1'b0;
            hit_run     = '0;
            s.evt       = EVT_CLEARED;
          end
        end else begin
          clear_run = '0;
        end
      end
    end
    s.present = obstacle_on;
    summaries_due.push_back(s);
    restart_scan();
  endfunction

  function automatic void check_field(input string label, input int unsigned want_v,
                                      input int unsigned got_v);
    if (want_v != got_v) begin
      mismatches++;
      $display("%0t ns: %s expected %0d, got %0d", $time, label, want_v, got_v);
    end
  endfunction

  // Output transactions are checked before the input of the same edge is
  // folded in; a result never belongs to a sample accepted at that edge
  always @(posedge clk) begin
    scan_summary_t want;
    if (rst) begin
      restore_defaults();
      summaries_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (summaries_due.size() == 0) begin
          mismatches++;
          $display("%0t ns: result with none expected, got min %0d found %0b obst %0b evt %0d",
                   $time, front_minimum, minimum_found, obstacle_present, event_code);
        end else begin
          want = summaries_due.pop_front();
          check_field("front_minimum", want.minimum, front_minimum);
          check_field("minimum_found", want.found, minimum_found);
          check_field("obstacle_present", want.present, obstacle_present);
          check_field("event_code", want.evt, event_code);
        end
      end
      if (cfg_write) apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) absorb_sample(sample_range, sample_finite, scan_end);
    end
    outstanding = summaries_due.size();
  end

endmodule

// ===== dv/scan_window_obstacle_guard_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the scan window obstacle guard: clock, reset, register
// programming, sample stimulus, receiver back-pressure and the verdict.
// Depends on swog_pkg, scan_window_obstacle_guard and its checker.
module scan_window_obstacle_guard_tb;
  import swog_pkg::*;

  localparam int RANGE_BITS      = 16;
  localparam int INDEX_BITS      = 12;
  localparam int STREAK_BITS     = 8;
  localparam int CFG_BITS        = 16;
  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 60;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_write;
  logic [REG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]       cfg_data;
  logic                      in_valid, in_ready;
  logic [RANGE_BITS-1:0]     sample_range;
  logic                      sample_finite, scan_end;
  logic                      out_valid, out_ready;
  logic [RANGE_BITS-1:0]     front_minimum;
  logic                      minimum_found, obstacle_present;
  logic [EVENT_BITS-1:0]     event_code;

  int mismatches, outstanding;
  int send_idle_pct, recv_idle_pct, hold_cycles, quiet_cycles, samples_sent;
  // current register values, used to aim samples at the thresholds
  int cur_trig, cur_rel, cur_vlo, cur_vhi;

  scan_window_obstacle_guard #(
    .RANGE_BITS (RANGE_BITS),
    .INDEX_BITS (INDEX_BITS),
    .STREAK_BITS(STREAK_BITS)
  ) dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .sample_range, .sample_finite, .scan_end,
    .out_valid, .out_ready, .front_minimum, .minimum_found, .obstacle_present,
    .event_code
  );

  scan_window_obstacle_guard_checker #(
    .RANGE_BITS (RANGE_BITS),
    .INDEX_BITS (INDEX_BITS),
    .STREAK_BITS(STREAK_BITS),
    .CFG_BITS   (CFG_BITS)
  ) guard_check (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .sample_range, .sample_finite, .scan_end,
    .out_valid, .out_ready, .front_minimum, .minimum_found, .obstacle_present,
    .event_code, .mismatches, .outstanding
  );

  always #1 clk = ~clk;

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, or a counted hold-off when one is requested
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic put_reg(input logic [REG_INDEX_BITS-1:0] idx,
                         input logic [CFG_BITS-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // Writes every register; only called once the block is drained
  task automatic program_guard(input int trig, input int rel, input int hits,
                               input int clears, input int wlo, input int whi,
                               input int vlo, input int vhi);
    put_reg(REG_HIT_THRESHOLD, CFG_BITS'(trig));
    put_reg(REG_CLEAR_THRESHOLD, CFG_BITS'(rel));
    put_reg(REG_HITS_NEEDED, CFG_BITS'(hits));
    put_reg(REG_CLEARS_NEEDED, CFG_BITS'(clears));
    put_reg(REG_WINDOW_FIRST_INDEX, CFG_BITS'(wlo));
    put_reg(REG_WINDOW_LAST_INDEX, CFG_BITS'(whi));
    put_reg(REG_MIN_VALID_RANGE, CFG_BITS'(vlo));
    put_reg(REG_MAX_VALID_RANGE, CFG_BITS'(vhi));
    cfg_write <= 1'b0;
    cur_trig = trig;
    cur_rel  = rel;
    cur_vlo  = vlo;
    cur_vhi  = vhi;
  endtask

  // One input transaction, with an optional random gap in front of it
  task automatic send_sample(input logic [RANGE_BITS-1:0] rng, input logic fin,
                             input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    sample_range  <= rng;
    sample_finite <= fin;
    scan_end      <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    samples_sent++;
  endtask

  // Wait until every scan summary is out, plus the pipeline depth
  task automatic drain();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Mostly close to the aim value, sometimes an extreme, a random value or a bound
  function automatic logic [RANGE_BITS-1:0] pick_range(input int aim);
    int v;
    case ($urandom_range(19))
      0:      return '0;
      1:      return '1;
      2, 3:   return RANGE_BITS'($urandom);
      4:      v = cur_vlo;
      5:      v = cur_vhi;
      default: v = aim;
    endcase
    v = v + int'($urandom_range(8)) - 4;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return RANGE_BITS'(v);
  endfunction

  // A scan aimed at a hit, a clear or anything
  task automatic send_scan(input int len);
    int aim;
    case ($urandom_range(3))
      0:       aim = cur_trig;
      1:       aim = cur_rel;
      2:       aim = int'($urandom_range(65535));
      default: aim = ($urandom_range(1)) ? cur_trig : cur_rel;
    endcase
    for (int k = 0; k < len; k++) begin
      send_sample(pick_range(aim), 1'($urandom_range(99) < 85), k == len - 1);
    end
  endtask

  task automatic randomise_guard();
    int trig, rel, hits, clears, wlo, whi, vlo, vhi;
    trig = int'($urandom_range(3000));
    case ($urandom_range(4))
      0:       rel = trig - int'($urandom_range(trig));
      1:       rel = int'($urandom_range(65535));
      default: rel = trig + int'($urandom_range(1500, 1));
    endcase
    hits   = ($urandom_range(9) == 0) ? int'($urandom_range(255)) : int'($urandom_range(3));
    clears = ($urandom_range(9) == 0) ? int'($urandom_range(255)) : int'($urandom_range(3));
    wlo = int'($urandom_range(6));
    whi = wlo + int'($urandom_range(12));
    case ($urandom_range(9))
      0: begin
        wlo = int'($urandom_range(15, 3));
        whi = wlo - 1 - int'($urandom_range(2));
      end
      1:       whi = 4095;
      default: ;
    endcase
    vlo = int'($urandom_range(100));
    vhi = int'($urandom_range(65535, 1000));
    if ($urandom_range(9) == 0) begin
      vlo = 60000;
      vhi = int'($urandom_range(59999));
    end
    program_guard(trig, rel, hits, clears, wlo, whi, vlo, vhi);
  endtask

  initial begin
    int target;
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = REG_HIT_THRESHOLD;
    cfg_data      = '0;
    in_valid      = 1'b0;
    sample_range  = '0;
    sample_finite = 1'b0;
    scan_end      = 1'b0;
    quiet_cycles  = 0;
    hold_cycles   = 0;
    samples_sent  = 0;
    send_idle_pct = 14;
    recv_idle_pct = 83;
    cur_trig      = 200;
    cur_rel       = 300;
    cur_vlo       = 0;
    cur_vhi       = 65535;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Reset defaults: detect, clear, empty scan, between thresholds
    send_sample(16'd0, 1'b1, 1'b1);
    send_sample(16'hFFFF, 1'b1, 1'b1);
    send_sample(16'd100, 1'b0, 1'b1);
    send_sample(16'd500, 1'b1, 1'b0);
    send_sample(16'd150, 1'b1, 1'b0);
    send_sample(16'd300, 1'b1, 1'b1);
    send_sample(16'd250, 1'b1, 1'b1);
    send_sample(16'd300, 1'b1, 1'b1);
    send_sample(16'd199, 1'b0, 1'b0);
    send_sample(16'd201, 1'b1, 1'b1);

    // Extreme thresholds, zero needed counts
    drain();
    program_guard(65535, 0, 0, 0, 0, 4095, 0, 65535);
    send_sample(16'd1000, 1'b1, 1'b1);
    send_sample(16'd1000, 1'b1, 1'b1);
    send_sample(16'hFFFF, 1'b1, 1'b0);
    send_sample(16'd0, 1'b1, 1'b1);

    // Inverted window, then inverted valid bounds: all scans empty
    drain();
    program_guard(0, 65535, 255, 255, 4095, 0, 0, 65535);
    send_sample(16'd0, 1'b1, 1'b1);
    send_sample(16'hFFFF, 1'b1, 1'b0);
    send_sample(16'd5, 1'b1, 1'b1);
    drain();
    program_guard(0, 65535, 255, 255, 0, 4095, 65535, 0);
    send_sample(16'd0, 1'b1, 1'b0);
    send_sample(16'hFFFF, 1'b1, 1'b1);

    // Random part in three idling regimes
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 83 : 0;
      recv_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 14 : 0;
      for (int setting = 0; setting < 3; setting++) begin
        drain();
        randomise_guard();
        // long receiver hold-off while one-sample scans pile up
        if (phase == 2 && setting == 0) begin
          hold_cycles = HOLD_OFF_CYCLES;
          repeat (20) send_sample(pick_range(cur_trig), 1'b1, 1'b1);
        end
        target = samples_sent + 72;
        while (samples_sent < target) send_scan(int'($urandom_range(10, 1)));
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
